[sv/bir_pkg.sv]
// ============================================================================
// bir_pkg
// Shared types and constants of the bicubic image resizer.
// ============================================================================
`default_nettype none

package bir_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_TAPS   = 33;

    // configuration register indexes
    localparam logic [1:0] REG_IN_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IN_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
    localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

    localparam int REG_W   = 11;
    localparam int COORD_W = 10;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [REG_W-1:0] REG_RESET = 11'd1024;

    // divider sizes and datapath widths
    localparam int DDW  = 56;   // dividend / quotient
    localparam int DVW  = 32;   // divisor
    localparam int FW   = 27;   // scale and center, Q16
    localparam int LW   = 12;   // tap position
    localparam int KW   = 24;   // raw kernel value, Q22
    localparam int WW   = 46;   // normalized weight
    localparam int ACCW = 64;   // accumulators

    // divider operand selection
    localparam logic [1:0] DIV_SCALE  = 2'd0;
    localparam logic [1:0] DIV_CENTER = 2'd1;
    localparam logic [1:0] DIV_U      = 2'd2;
    localparam logic [1:0] DIV_NORM   = 2'd3;

    typedef struct packed {
        logic       axis;
        logic       div_start;
        logic [1:0] div_sel;
        logic       ld_f;
        logic       ld_c;
        logic       ld_range;
        logic       ld_u;
        logic       k1;
        logic       k2;
        logic       k3;
        logic       idx_clr;
        logic       nrd;
        logic       nwr;
        logic       acc_clr;
        logic       row_clr;
        logic       hrd;
        logic       hmac;
        logic       vrd;
        logic       vmac;
        logic       out_ld;
        logic       err_ld;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic bad_cfg;
        logic range_err;
        logic tap_end;
        logic h_end;
        logic v_end;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

[sv/bir_ram.sv]
// ============================================================================
// bir_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
`default_nettype none

module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/bir_div.sv]
// ============================================================================
// bir_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module bir_div #(
    parameter int NW = 56,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic      [NW-1:0] quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DW:0]     trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNTW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[sv/bir_dp.sv]
// ============================================================================
// bir_dp
// Datapath: registers, frame store, weight store, divider, kernel and MACs.
// ============================================================================
`default_nettype none

module bir_dp #(
    parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_TAPS   = bir_pkg::DEF_MAX_TAPS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [bir_pkg::REG_W-1:0]          cfg_data,
    input  wire logic                               in_fire,
    input  wire logic                               in_op,
    input  wire logic [bir_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic      [bir_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic      [0:0]                         m_tuser,
    input  wire bir_pkg::cmd_t                      cmd,
    output bir_pkg::stat_t                          stat
);

    import bir_pkg::*;

    localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FAW    = $clog2(FDEPTH);
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int WDEPTH = 2 * MAX_TAPS;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int SUMW   = KW + TW;

    // configuration
    logic [REG_W-1:0] in_w_reg, in_h_reg, out_w_reg, out_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_w_reg  <= REG_RESET;
            in_h_reg  <= REG_RESET;
            out_w_reg <= REG_RESET;
            out_h_reg <= REG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH:   in_w_reg  <= cfg_data;
                REG_IN_HEIGHT:  in_h_reg  <= cfg_data;
                REG_OUT_WIDTH:  out_w_reg <= cfg_data;
                REG_OUT_HEIGHT: out_h_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // request fields
    logic [COORD_W-1:0] in_x, in_y;
    logic [PIX_W-1:0]   in_pix;
    logic [COORD_W-1:0] cx_reg, cy_reg;

    assign in_x   = s_tdata[9:0];
    assign in_y   = s_tdata[19:10];
    assign in_pix = {s_tdata[27:20], s_tdata[35:28], s_tdata[43:36]};

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cx_reg <= in_x;
            cy_reg <= in_y;
        end
    end

    // frame store
    logic           fs_we;
    logic [FAW-1:0] fs_waddr, fs_raddr;
    logic [PIX_W-1:0] fs_rdata;

    assign fs_we    = in_fire && !in_op && (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);
    assign fs_waddr = FAW'(in_y) * FAW'(MAX_WIDTH) + FAW'(in_x);

    bir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FDEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (in_pix),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    // axis selection
    logic [REG_W-1:0]   ax_n, ax_m;
    logic [COORD_W-1:0] ax_p;

    assign ax_n = cmd.axis ? in_h_reg  : in_w_reg;
    assign ax_m = cmd.axis ? out_h_reg : out_w_reg;
    assign ax_p = cmd.axis ? cy_reg    : cx_reg;

    assign stat.bad_cfg = (in_w_reg == '0) || (in_h_reg == '0) || (out_w_reg == '0) ||
                          (out_h_reg == '0) ||
                          (32'(in_w_reg) > MAX_WIDTH) || (32'(out_w_reg) > MAX_WIDTH) ||
                          (32'(in_h_reg) > MAX_HEIGHT) || (32'(out_h_reg) > MAX_HEIGHT) ||
                          ({1'b0, cx_reg} >= out_w_reg) || ({1'b0, cy_reg} >= out_h_reg);

    // state registers of the coefficient pass
    logic [FW-1:0]          f_reg, c_reg;
    logic [LW-1:0]          h_lo_reg, v_lo_reg;
    logic [TW-1:0]          h_cnt_reg, v_cnt_reg;
    logic [TW-1:0]          idx_reg, row_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [22:0]            u_reg;
    logic                   u_big_reg;
    logic [23:0]            r1_reg, r2_reg;
    logic                   neg_reg;

    // tap range
    logic [31:0]        cs, fs2;
    logic signed [31:0] lo_t, hi_t, lo_v, hi_v, diff;

    always_comb
    begin
        cs   = {5'b0, c_reg};
        fs2  = {4'b0, f_reg, 1'b0};
        lo_t = $signed(cs) - $signed(fs2) + 32'sd32768;
        hi_t = $signed(cs + fs2 + 32'd32768) >>> 16;
        lo_v = lo_t[31] ? 32'sd0 : (lo_t >>> 16);
        hi_v = (hi_t > $signed({21'b0, ax_n})) ? $signed({21'b0, ax_n}) : hi_t;
        diff = hi_v - lo_v;
    end

    assign stat.range_err = diff > MAX_TAPS;

    // tap distance from the center
    logic [LW-1:0]      ax_lo, x_tap;
    logic signed [31:0] dx;
    logic [31:0]        dabs;

    assign ax_lo = cmd.axis ? v_lo_reg : h_lo_reg;
    assign x_tap = ax_lo + LW'(idx_reg);
    assign dx    = $signed({4'b0, x_tap, 16'h8000}) - $signed({5'b0, c_reg});
    assign dabs  = dx[31] ? 32'(-dx) : 32'(dx);

    // weight store
    logic           w_we;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [WW-1:0]  w_wdata, w_rdata;
    logic signed [WW-1:0] w_rd;

    assign w_rd = $signed(w_rdata);

    bir_ram #(
        .WIDTH (WW),
        .DEPTH (WDEPTH)
    ) u_wts (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // divider
    logic [DDW-1:0] div_a, div_q;
    logic [DVW-1:0] div_b;
    logic [WW-1:0]  kabs;
    logic [SUMW-1:0] sabs;
    logic           sum_nz;

    assign kabs   = w_rd[WW-1] ? WW'(-w_rd) : w_rdata;
    assign sabs   = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign sum_nz = sum_reg != '0;

    always_comb
    begin
        logic [21:0] cprod;
        cprod = {ax_p, 1'b1} * ax_n;
        case (cmd.div_sel)
            DIV_SCALE:
            begin
                div_a = DDW'({ax_n, 16'b0});
                div_b = DVW'(ax_m);
            end
            DIV_CENTER:
            begin
                div_a = DDW'({cprod, 15'b0});
                div_b = DVW'(ax_m);
            end
            DIV_U:
            begin
                div_a = DDW'({dabs, 22'b0});
                div_b = DVW'(f_reg);
            end
            default:
            begin
                div_a = sum_nz ? DDW'({kabs, 22'b0}) : DDW'({kabs, 16'b0});
                div_b = sum_nz ? DVW'(sabs) : DVW'(f_reg);
            end
        endcase
    end

    bir_div #(
        .NW (DDW),
        .DW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (stat.div_busy),
        .done     (stat.div_done),
        .quotient (div_q)
    );

    // kernel: two chained products, registered after each
    logic [23:0] uu, kx, ky;
    logic [47:0] prod1, prod2;
    logic        lt1;
    logic [27:0] ka, kb;
    logic signed [KW-1:0] kval;

    always_comb
    begin
        uu    = {1'b0, u_reg};
        lt1   = !u_reg[22];
        kx    = lt1 ? uu : uu - 24'h400000;
        ky    = lt1 ? uu : 24'h800000 - uu;
        prod1 = kx * ky;
        prod2 = r1_reg * ky;
        ka    = 28'h0800000 + 28'(r2_reg) * 28'd3;
        kb    = 28'(r1_reg) * 28'd5;
        if (u_big_reg)
        begin
            kval = '0;
        end
        else if (lt1)
        begin
            kval = (ka < kb) ? '0 : $signed(KW'((ka - kb) >> 1));
        end
        else
        begin
            kval = -$signed(KW'(r2_reg >> 1));
        end
    end

    // weight write port
    logic [WW-1:0] qw;
    assign qw = div_q[WW-1:0];

    always_comb
    begin
        w_we    = cmd.k3 || cmd.nwr;
        w_waddr = cmd.axis ? WAW'(MAX_TAPS) + WAW'(idx_reg) : WAW'(idx_reg);
        w_wdata = cmd.k3 ? WW'(kval) : (neg_reg ? WW'(-qw) : qw);
        if (cmd.vrd)
        begin
            w_raddr = WAW'(MAX_TAPS) + WAW'(row_reg);
        end
        else if (cmd.nrd)
        begin
            w_raddr = w_waddr;
        end
        else
        begin
            w_raddr = WAW'(idx_reg);
        end
    end

    // frame read address
    logic [LW-1:0] row_pos, col_pos;
    assign row_pos  = v_lo_reg + LW'(row_reg);
    assign col_pos  = h_lo_reg + LW'(idx_reg);
    assign fs_raddr = FAW'(row_pos) * FAW'(MAX_WIDTH) + FAW'(col_pos);

    assign stat.tap_end = idx_reg == (cmd.axis ? v_cnt_reg : h_cnt_reg);
    assign stat.h_end   = idx_reg == h_cnt_reg;
    assign stat.v_end   = row_reg == v_cnt_reg;

    // round half up and clip to 8 bits
    function automatic logic [CHAN_W-1:0] clip_round(input logic signed [ACCW-1:0] a);
        logic signed [ACCW-1:0] t;
        logic signed [ACCW-1:0] s;
        t = a + ACCW'(64'sd2097152);
        s = t >>> 22;
        if (t[ACCW-1])
        begin
            return '0;
        end
        else if (s > 255)
        begin
            return 8'hFF;
        end
        else
        begin
            return s[CHAN_W-1:0];
        end
    endfunction

    // MAC accumulators, channel 0 is red
    logic signed [ACCW-1:0] h_reg [3];
    logic signed [ACCW-1:0] acc_reg [3];

    always_ff @(posedge clk)
    begin
        if (cmd.ld_f)
        begin
            f_reg <= (div_q < DDW'(65536)) ? FW'(65536) : div_q[FW-1:0];
        end
        if (cmd.ld_c)
        begin
            c_reg <= div_q[FW-1:0];
        end
        if (cmd.ld_range)
        begin
            if (cmd.axis)
            begin
                v_lo_reg  <= lo_v[LW-1:0];
                v_cnt_reg <= (diff > 0) ? diff[TW-1:0] : '0;
            end
            else
            begin
                h_lo_reg  <= lo_v[LW-1:0];
                h_cnt_reg <= (diff > 0) ? diff[TW-1:0] : '0;
            end
        end
        if (cmd.ld_u)
        begin
            u_reg     <= div_q[22:0];
            u_big_reg <= |div_q[DDW-1:23];
        end
        if (cmd.k1)
        begin
            r1_reg <= prod1[45:22];
        end
        if (cmd.k2)
        begin
            r2_reg <= prod2[45:22];
        end
        if (cmd.ld_range)
        begin
            sum_reg <= '0;
        end
        else if (cmd.k3)
        begin
            sum_reg <= sum_reg + SUMW'(kval);
        end
        if (cmd.div_start && cmd.div_sel == DIV_NORM)
        begin
            neg_reg <= w_rd[WW-1] ^ (sum_nz && sum_reg[SUMW-1]);
        end
        if (cmd.ld_range || cmd.idx_clr || cmd.row_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.k3 || cmd.nwr || cmd.hmac)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.acc_clr)
        begin
            row_reg <= '0;
        end
        else if (cmd.vmac)
        begin
            row_reg <= row_reg + 1'b1;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (cmd.row_clr)
            begin
                h_reg[ch] <= '0;
            end
            else if (cmd.hmac)
            begin
                h_reg[ch] <= h_reg[ch] + ACCW'(w_rd * $signed({1'b0,
                             fs_rdata[PIX_W-1-CHAN_W*ch -: CHAN_W]}));
            end
            if (cmd.acc_clr)
            begin
                acc_reg[ch] <= '0;
            end
            else if (cmd.vmac)
            begin
                acc_reg[ch] <= acc_reg[ch] + ACCW'(w_rd * $signed({1'b0,
                               clip_round(h_reg[ch])}));
            end
        end
    end

    // result register
    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_pix_reg;
    logic                out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld || cmd.err_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_pix_reg <= {clip_round(acc_reg[2]), clip_round(acc_reg[1]),
                            clip_round(acc_reg[0])};
            out_err_reg <= 1'b0;
        end
        else if (cmd.err_ld)
        begin
            out_pix_reg <= '0;
            out_err_reg <= 1'b1;
        end
    end

    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_pix_reg;
    assign m_tuser       = out_err_reg;

endmodule

`default_nettype wire

[sv/bir_ctrl.sv]
// ============================================================================
// bir_ctrl
// Sequencer: coefficient pass per axis, then the two-pass filter.
// ============================================================================
`default_nettype none

module bir_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire bir_pkg::stat_t stat,
    output bir_pkg::cmd_t       cmd,
    output logic                idle
);

    import bir_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_ERR   = 5'd2;
    localparam logic [4:0] S_SCL   = 5'd3;
    localparam logic [4:0] S_SCLW  = 5'd4;
    localparam logic [4:0] S_CEN   = 5'd5;
    localparam logic [4:0] S_CENW  = 5'd6;
    localparam logic [4:0] S_RNG   = 5'd7;
    localparam logic [4:0] S_TAP   = 5'd8;
    localparam logic [4:0] S_TAPW  = 5'd9;
    localparam logic [4:0] S_K1    = 5'd10;
    localparam logic [4:0] S_K2    = 5'd11;
    localparam logic [4:0] S_K3    = 5'd12;
    localparam logic [4:0] S_NCLR  = 5'd13;
    localparam logic [4:0] S_NRD   = 5'd14;
    localparam logic [4:0] S_NDIV  = 5'd15;
    localparam logic [4:0] S_NDIVW = 5'd16;
    localparam logic [4:0] S_NWR   = 5'd17;
    localparam logic [4:0] S_ACC   = 5'd18;
    localparam logic [4:0] S_ROW   = 5'd19;
    localparam logic [4:0] S_HRD   = 5'd20;
    localparam logic [4:0] S_HMAC  = 5'd21;
    localparam logic [4:0] S_VRD   = 5'd22;
    localparam logic [4:0] S_VMAC  = 5'd23;
    localparam logic [4:0] S_OUT   = 5'd24;

    logic [4:0] state_reg, state_next;
    logic       axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                axis_next  = 1'b0;
                state_next = stat.bad_cfg ? S_ERR : S_SCL;
            end
            S_ERR:
            begin
                if (!stat.out_busy)
                begin
                    cmd.err_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SCALE;
                state_next    = S_SCLW;
            end
            S_SCLW:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_f   = 1'b1;
                    state_next = S_CEN;
                end
            end
            S_CEN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CENTER;
                state_next    = S_CENW;
            end
            S_CENW:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_c   = 1'b1;
                    state_next = S_RNG;
                end
            end
            S_RNG:
            begin
                if (stat.range_err)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.ld_range = 1'b1;
                    state_next   = S_TAP;
                end
            end
            S_TAP:
            begin
                if (stat.tap_end)
                begin
                    state_next = S_NCLR;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_U;
                    state_next    = S_TAPW;
                end
            end
            S_TAPW:
            begin
                if (stat.div_done)
                begin
                    cmd.ld_u   = 1'b1;
                    state_next = S_K1;
                end
            end
            S_K1:
            begin
                cmd.k1     = 1'b1;
                state_next = S_K2;
            end
            S_K2:
            begin
                cmd.k2     = 1'b1;
                state_next = S_K3;
            end
            S_K3:
            begin
                cmd.k3     = 1'b1;
                state_next = S_TAP;
            end
            S_NCLR:
            begin
                cmd.idx_clr = 1'b1;
                state_next  = S_NRD;
            end
            S_NRD:
            begin
                if (stat.tap_end)
                begin
                    if (axis_reg)
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = S_SCL;
                    end
                end
                else
                begin
                    cmd.nrd    = 1'b1;
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NORM;
                state_next    = S_NDIVW;
            end
            S_NDIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = S_NWR;
                end
            end
            S_NWR:
            begin
                cmd.nwr    = 1'b1;
                state_next = S_NRD;
            end
            S_ACC:
            begin
                cmd.acc_clr = 1'b1;
                state_next  = S_ROW;
            end
            S_ROW:
            begin
                if (stat.v_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.row_clr = 1'b1;
                    state_next  = S_HRD;
                end
            end
            S_HRD:
            begin
                if (stat.h_end)
                begin
                    state_next = S_VRD;
                end
                else
                begin
                    cmd.hrd    = 1'b1;
                    state_next = S_HMAC;
                end
            end
            S_HMAC:
            begin
                cmd.hmac   = 1'b1;
                state_next = S_HRD;
            end
            S_VRD:
            begin
                cmd.vrd    = 1'b1;
                state_next = S_VMAC;
            end
            S_VMAC:
            begin
                cmd.vmac   = 1'b1;
                state_next = S_ROW;
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign idle = state_reg == S_IDLE;

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld || cmd.err_ld) |-> !stat.out_busy)
        else $error("result loaded while previous result still pending");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_SCLW || state_reg == S_CENW ||
                           state_reg == S_TAPW || state_reg == S_NDIVW))
        else $error("divider finished outside a wait state");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (idle && start) |=> state_reg == S_CHK)
        else $error("compute request did not start the sequencer");

endmodule

`default_nettype wire

[sv/bicubic_image_resize.sv]
// ============================================================================
// bicubic_image_resize
// Separable bicubic RGB resizer with frame store and normalized weights.
// ============================================================================
// A load request (tuser 0) writes one pixel to the frame store, if its
// coordinates lie within the maximum frame size, and gives no result. A
// compute request (tuser 1) gives one result; the block takes no new request
// until that compute finishes. Its length is set by the shared divider, one
// quotient bit per cycle: per axis two divisions for scale and center plus
// two per tap (kernel argument and normalization), then in the filter a frame
// store read and a multiply-accumulate per tap and a weight read and a
// multiply-accumulate per row. The frame store is not cleared: read only
// pixels that were loaded.
`default_nettype none

module bicubic_image_resize #(
    parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_TAPS   = bir_pkg::DEF_MAX_TAPS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [bir_pkg::REG_W-1:0]       cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // coord_x, coord_y, red_in, green_in, blue_in, zero fill
    input  wire logic [bir_pkg::IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // red_out, green_out, blue_out
    output logic      [bir_pkg::OUT_TDATA_W-1:0] m_tdata,
    // error
    output logic      [0:0]                      m_tuser
);

    import bir_pkg::*;

    cmd_t cmd;
    stat_t stat;
    logic idle;
    logic in_fire;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    bir_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire && s_tuser[0]),
        .stat  (stat),
        .cmd   (cmd),
        .idle  (idle)
    );

    bir_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_TAPS   (MAX_TAPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_op     (s_tuser[0]),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
